// ----- sv/kcg_pkg.sv -----
`timescale 1ns / 1ps

package kcg_pkg;

    // Fixed widths of the transaction fields.
    localparam int MODE_W     = 2;
    localparam int LOAD_IDX_W = 6;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 4;
    localparam int INDEX_W    = 6;
    localparam int COUNT_W    = 49;
    localparam int K_W        = 5;
    localparam int N_W        = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_mode MODE_LOAD    = 2'd0;
    localparam t_mode MODE_RESTART = 2'd1;
    localparam t_mode MODE_NEXT    = 2'd2;

    localparam t_cfg_idx REG_SUBSET_SIZE = 1'b0;
    localparam t_cfg_idx REG_SET_SIZE    = 1'b1;

    localparam logic [K_W-1:0] SUBSET_SIZE_RESET = 5'd2;
    localparam logic [N_W-1:0] SET_SIZE_RESET    = 7'd3;

endpackage

// ----- sv/k_combination_generator_unit.sv -----
`timescale 1ns / 1ps

// Lexicographic k-combination generator. Load the item table with mode 0, then
// issue a restart (mode 1) and further next requests (mode 2); a transaction is taken when
// i_start is high and o_busy is low. Each combination is sent as k consecutive strobes on
// o_valid, one per element, and the receiver must take every strobe as it comes, since there is
// no back-pressure. When nothing remains, or the sizes are invalid, a single strobe with
// o_done_res set is sent instead. Timing is set by an index memory (one read, one write port)
// walked by a small sequencer: a restart keeps o_busy high while every stored index is rewritten;
// a next request while positions are scanned down to the one that advances and refilled above it;
// a load, an unused mode, or a done answer taken straight away leaves o_busy low.
// Results pass from the index-memory read register through the output registers.
module k_combination_generator_unit #(
    parameter int MAX_SUBSET = 16,
    parameter int MAX_ITEMS  = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  kcg_pkg::t_mode                       i_mode,
    input  logic [kcg_pkg::LOAD_IDX_W-1:0]       i_load_index,
    input  logic signed [kcg_pkg::VALUE_W-1:0]   i_load_value,
    input  logic                                 i_cfg_we,
    input  kcg_pkg::t_cfg_idx                    i_cfg_index,
    input  logic [kcg_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                 o_valid,
    output logic signed [kcg_pkg::VALUE_W-1:0]   o_element_value,
    output logic [kcg_pkg::POS_W-1:0]            o_element_position,
    output logic [kcg_pkg::INDEX_W-1:0]          o_element_index,
    output logic                                 o_last_element,
    output logic                                 o_done_res,
    output logic [kcg_pkg::COUNT_W-1:0]          o_combination_count
);
    import kcg_pkg::*;

    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int NW = $clog2(MAX_ITEMS + 1);
    localparam int AW = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;
    localparam int PW = $clog2(MAX_SUBSET + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN_RD,
        S_SCAN,
        S_FILL,
        S_EMIT
    } t_state;

    t_state r_state;

    logic [K_W-1:0]     r_subset_size;
    logic [N_W-1:0]     r_set_size;
    logic               r_started;
    logic               r_exhausted;
    logic [COUNT_W-1:0] r_count;
    logic [PW-1:0]      r_p;
    logic [PW-1:0]      r_k;
    logic [NW-1:0]      r_bound;
    logic [IW-1:0]      r_val;

    logic               r_s1_valid;
    logic [PW-1:0]      r_s1_pos;
    logic               r_s1_last;

    logic               r_o_valid;
    logic [POS_W-1:0]   r_o_pos;
    logic [INDEX_W-1:0] r_o_index;
    logic               r_o_last;
    logic               r_o_done;
    logic [COUNT_W-1:0] r_o_count;

    logic [IW-1:0]      r_ci_mem [MAX_SUBSET];
    logic [IW-1:0]      r_ci_rdata;
    logic [VALUE_W-1:0] r_item_mem [MAX_ITEMS];
    logic [VALUE_W-1:0] r_item_rdata;

    logic               start_acc;
    logic               sizes_ok;
    logic [NW-1:0]      n_eff;
    logic               ci_we;
    logic [AW-1:0]      ci_waddr;
    logic [IW-1:0]      ci_wdata;
    logic [AW-1:0]      ci_raddr;
    logic               tbl_we;
    logic               scan_hit;

    assign o_busy    = (r_state != S_IDLE) || r_s1_valid;
    assign start_acc = i_start && !o_busy;

    assign n_eff    = (32'(r_set_size) > MAX_ITEMS) ? NW'(MAX_ITEMS) : NW'(r_set_size);
    assign sizes_ok = (r_subset_size != '0) && (32'(r_subset_size) <= 32'(n_eff))
                      && (32'(r_subset_size) <= MAX_SUBSET);

    assign scan_hit = 32'(r_ci_rdata) < 32'(r_bound);

    assign tbl_we = start_acc && (i_mode == MODE_LOAD) && (32'(i_load_index) < MAX_ITEMS);

    // During the scan the next lower position is read ahead of the compare.
    assign ci_raddr = (r_state == S_SCAN) ? AW'(r_p - PW'(1)) : AW'(r_p);

    always_comb begin
        ci_we    = 1'b0;
        ci_waddr = AW'(r_p);
        ci_wdata = '0;
        unique case (r_state)
            S_INIT: begin
                ci_we    = 1'b1;
                ci_wdata = (r_p < r_k) ? IW'(r_p) : '0;
            end
            S_SCAN: begin
                ci_we    = scan_hit;
                ci_wdata = r_ci_rdata + IW'(1);
            end
            S_FILL: begin
                ci_we    = (r_p != r_k);
                ci_wdata = r_val + IW'(1);
            end
            default: begin
                ci_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ci_we) begin
            r_ci_mem[ci_waddr] <= ci_wdata;
        end
        r_ci_rdata <= r_ci_mem[ci_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_item_mem[IW'(i_load_index)] <= i_load_value;
        end
        r_item_rdata <= r_item_mem[r_ci_rdata];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subset_size <= SUBSET_SIZE_RESET;
            r_set_size    <= SET_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SUBSET_SIZE: r_subset_size <= i_cfg_data[K_W-1:0];
                REG_SET_SIZE:    r_set_size    <= i_cfg_data[N_W-1:0];
                default:         r_set_size    <= r_set_size;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_exhausted <= 1'b0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_o_valid   <= 1'b0;
            r_o_done    <= 1'b0;
        end else begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= r_s1_valid;
            r_o_done   <= 1'b0;
            r_o_pos    <= POS_W'(r_s1_pos);
            r_o_index  <= INDEX_W'(r_ci_rdata);
            r_o_last   <= r_s1_last;
            r_o_count  <= r_count;

            unique case (r_state)
                S_IDLE: begin
                    if (start_acc && ((i_mode == MODE_RESTART)
                                      || ((i_mode == MODE_NEXT) && !r_started))) begin
                        r_started   <= 1'b1;
                        r_exhausted <= 1'b0;
                        r_count     <= '0;
                        r_k         <= PW'(r_subset_size);
                        r_p         <= '0;
                        if (sizes_ok) begin
                            r_state <= S_INIT;
                        end else begin
                            r_exhausted <= 1'b1;
                            r_o_valid   <= 1'b1;
                            r_o_done    <= 1'b1;
                            r_o_pos     <= '0;
                            r_o_index   <= '0;
                            r_o_last    <= 1'b0;
                            r_o_count   <= '0;
                        end
                    end else if (start_acc && (i_mode == MODE_NEXT)) begin
                        r_k     <= PW'(r_subset_size);
                        r_p     <= PW'(r_subset_size) - PW'(1);
                        r_bound <= n_eff - NW'(1);
                        if (r_exhausted || !sizes_ok) begin
                            r_exhausted <= 1'b1;
                            r_o_valid   <= 1'b1;
                            r_o_done    <= 1'b1;
                            r_o_pos     <= '0;
                            r_o_index   <= '0;
                            r_o_last    <= 1'b0;
                            r_o_count   <= '0;
                        end else begin
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_INIT: begin
                    if (r_p == PW'(MAX_SUBSET - 1)) begin
                        r_p     <= '0;
                        r_count <= r_count + COUNT_W'(1);
                        r_state <= S_EMIT;
                    end else begin
                        r_p <= r_p + PW'(1);
                    end
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // The bound for position p is n - k + p, lowered by one per step.
                    if (scan_hit) begin
                        r_val   <= r_ci_rdata + IW'(1);
                        r_p     <= r_p + PW'(1);
                        r_state <= S_FILL;
                    end else if (r_p == '0) begin
                        r_exhausted <= 1'b1;
                        r_o_valid   <= 1'b1;
                        r_o_done    <= 1'b1;
                        r_o_pos     <= '0;
                        r_o_index   <= '0;
                        r_o_last    <= 1'b0;
                        r_o_count   <= '0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_p     <= r_p - PW'(1);
                        r_bound <= r_bound - NW'(1);
                    end
                end
                S_FILL: begin
                    if (r_p == r_k) begin
                        r_p     <= '0;
                        r_count <= r_count + COUNT_W'(1);
                        r_state <= S_EMIT;
                    end else begin
                        r_val <= r_val + IW'(1);
                        r_p   <= r_p + PW'(1);
                    end
                end
                S_EMIT: begin
                    r_s1_valid <= 1'b1;
                    r_s1_pos   <= r_p;
                    r_s1_last  <= (r_p == r_k - PW'(1));
                    if (r_p == r_k - PW'(1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_p <= r_p + PW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid             = r_o_valid;
    assign o_element_value     = r_o_done ? '0 : r_item_rdata;
    assign o_element_position  = r_o_pos;
    assign o_element_index     = r_o_index;
    assign o_last_element      = r_o_last;
    assign o_done_res          = r_o_done;
    assign o_combination_count = r_o_count;

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_p < r_k))
        else $error("emission position ran past the subset size");

    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_element && !o_done_res)
            |-> (o_element_position == POS_W'(r_k - PW'(1))))
        else $error("last element flagged at the wrong position");

    a_elements_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_done_res && !o_last_element)
            |=> (o_valid && (o_element_position == $past(o_element_position) + 4'd1)))
        else $error("elements of one combination were not sent back to back");

    a_busy_while_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> o_busy)
        else $error("new transaction could be taken while results were in flight");

endmodule
